// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the filter RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check a property only once reset was already released at the previous edge.
`define ASSERT_WARM(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ($past(rst_n) |-> (prop))) else $error("assertion failed");
`else
`define ASSERT_SYNC(label, clk, rst_n, prop)
`define ASSERT_WARM(label, clk, rst_n, prop)
`endif
`endif

// ===== rtl/core/wtm_pkg.sv =====
// Shared field widths and datapath opcodes of the trimmed-mean filter.
package wtm_pkg;

    localparam int CH_FIELD_W  = 3;
    localparam int SMP_FIELD_W = 12;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_CLEAR = 3'd1,
        OP_ACC   = 3'd2,
        OP_MUL_T = 3'd3,
        OP_MUL_P = 3'd4
    } t_op;

endpackage

// ===== rtl/core/wtm_if.sv =====
// Valid/ready channel interfaces for the sample input and the result output.
interface wtm_in_if import wtm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CH_FIELD_W-1:0]  channel;
    logic [SMP_FIELD_W-1:0] sample;
    logic                   advance;

    modport source (output valid, output channel, output sample, output advance, input ready);
    modport sink   (input valid, input channel, input sample, input advance, output ready);
endinterface

interface wtm_out_if import wtm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CH_FIELD_W-1:0]  result_channel;
    logic [SMP_FIELD_W-1:0] trimmed_mean;
    logic [SMP_FIELD_W-1:0] plain_mean;

    modport source (output valid, output result_channel, output trimmed_mean,
                    output plain_mean, input ready);
    modport sink   (input valid, input result_channel, input trimmed_mean,
                    input plain_mean, output ready);
endinterface

// ===== rtl/core/wtm_store.sv =====
// Sample window memory with per-entry valid bits; unwritten entries read as zero.
`include "assert_macros.svh"

module wtm_store #(
    parameter int AW          = 7,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [SAMPLE_BITS-1:0] i_wr_data,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr,
    output logic [SAMPLE_BITS-1:0] o_rd_data
);

    localparam int DEPTH = 1 << AW;

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]       r_valid;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // never-written entries read back as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

    `ASSERT_WARM(a_valid_sticky, i_clk, i_rst_n, ((r_valid & $past(r_valid)) == $past(r_valid)))

endmodule

// ===== rtl/core/wtm_unit.sv =====
// Shared datapath: sum/min/max accumulation and reciprocal-multiply division.
`include "assert_macros.svh"

module wtm_unit import wtm_pkg::*; #(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  t_op                    i_op,
    input  logic [SAMPLE_BITS-1:0] i_data,
    output logic [SAMPLE_BITS-1:0] o_trimmed,
    output logic [SAMPLE_BITS-1:0] o_plain
);

    localparam int PW     = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + PW;
    localparam int TRIM_N = WINDOW - 2;
    // shift that keeps floor(x * M >> KSH) exact for every x below 2**SUM_W
    localparam int KSH    = SUM_W + PW;
    localparam int PROD_W = SUM_W + KSH;

    localparam logic [KSH-1:0]   M_TRIM    = KSH'((1 << KSH) / TRIM_N + 1);
    localparam logic [KSH-1:0]   M_PLAIN   = KSH'((1 << KSH) / WINDOW + 1);
    localparam logic [SUM_W-1:0] RND_TRIM  = SUM_W'(TRIM_N / 2);
    localparam logic [SUM_W-1:0] RND_PLAIN = SUM_W'(WINDOW / 2);

    logic [SUM_W-1:0]       r_sum;
    logic [SAMPLE_BITS-1:0] r_hi;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [PROD_W-1:0]      r_prod;
    logic [SAMPLE_BITS-1:0] r_trim;

    logic [SUM_W-1:0]  mul_a;
    logic [KSH-1:0]    mul_b;
    logic [PROD_W-1:0] product;

    // one multiplier, shared by both divisions
    always_comb begin
        if (i_op == OP_MUL_P) begin
            mul_a = r_sum + RND_PLAIN;
            mul_b = M_PLAIN;
        end else begin
            mul_a = r_sum - SUM_W'(r_hi) - SUM_W'(r_lo) + RND_TRIM;
            mul_b = M_TRIM;
        end
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_CLEAR: begin
                r_sum <= '0;
                r_hi  <= '0;
                r_lo  <= '1;
            end
            OP_ACC: begin
                r_sum <= r_sum + SUM_W'(i_data);
                if (i_data > r_hi) begin
                    r_hi <= i_data;
                end
                if (i_data < r_lo) begin
                    r_lo <= i_data;
                end
            end
            OP_MUL_T: begin
                r_prod <= product;
            end
            OP_MUL_P: begin
                r_trim <= r_prod[KSH +: SAMPLE_BITS];
                r_prod <= product;
            end
            default: begin
            end
        endcase
    end

    assign o_trimmed = r_trim;
    assign o_plain   = r_prod[KSH +: SAMPLE_BITS];

    `ASSERT_SYNC(a_hi_not_below_lo, i_clk, 1'b1, (i_op == OP_ACC) |=> (r_hi >= r_lo))

endmodule

// ===== rtl/core/windowed_trimmed_mean_filter.sv =====
// Top level of the windowed trimmed-mean filter: sequencer, store and shared datapath.
// Usage:
//   i_smp is a valid/ready sink; a transfer carries channel, sample and advance.
//   advance steps the shared write position (wrapping) before the sample is
//   written into that channel's window. o_res is a valid/ready source; each
//   input transfer yields exactly one result with the channel echoed, the
//   trimmed mean (sum less max and min, rounded, over WINDOW-2) and the plain
//   mean (sum rounded over WINDOW). A channel at or above CHANNELS stores
//   nothing and reports zero for both means.
// Timing:
//   One item is worked at a time. After the input transfer, the store is read
//   one entry per cycle (the single read port sets this rate), then S_DRAIN,
//   S_MUL_T and S_MUL_P on the shared multiplier and S_DONE to load the result:
//   the result shows when i_smp.ready also returns, so the next item is taken
//   in only once the last one is loaded into the output register.
// Reset and stall:
//   Synchronous reset clears the window store (via valid bits) and the write
//   position and holds i_smp.ready low. A stalled receiver holds the result in
//   the output register while the next item is taken in; that item then waits
//   in the last sequencer step until the register frees up.
`include "assert_macros.svh"

module windowed_trimmed_mean_filter import wtm_pkg::*; #(
    parameter int CHANNELS    = 8,
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    wtm_in_if.sink   i_smp,
    wtm_out_if.source o_res
);

    localparam int PW   = $clog2(WINDOW);
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW   = CH_W + PW;

    localparam logic [PW-1:0] LAST_POS = PW'(WINDOW - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_MUL_T = 6'b001000,
        S_MUL_P = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [PW-1:0]           r_pos;
    logic [PW-1:0]           n_pos;
    logic [PW-1:0]           r_idx;
    logic [CH_FIELD_W-1:0]   r_ch;
    logic                    r_blank;
    logic                    r_live;
    logic                    r_out_valid;
    logic [CH_FIELD_W-1:0]   r_out_ch;
    logic [SAMPLE_BITS-1:0]  r_out_trim;
    logic [SAMPLE_BITS-1:0]  r_out_plain;

    logic                    in_xfer;
    logic                    in_range;
    logic [CH_FIELD_W:0]     in_ch_ext;
    logic [CH_FIELD_W:0]     cur_ch_ext;
    logic                    rd_en;
    logic [SAMPLE_BITS-1:0]  rd_data;
    logic                    out_free;
    logic                    load_out;
    t_op                     op;
    logic [SAMPLE_BITS-1:0]  unit_trim;
    logic [SAMPLE_BITS-1:0]  unit_plain;

    assign i_smp.ready = (r_state == S_IDLE) && i_rst_n;
    assign in_xfer     = i_smp.valid && i_smp.ready;
    assign in_ch_ext   = {1'b0, i_smp.channel};
    assign cur_ch_ext  = {1'b0, r_ch};
    assign in_range    = int'(in_ch_ext) < CHANNELS;

    // step the shared position first, wrapping at the window end
    always_comb begin
        n_pos = r_pos;
        if (i_smp.advance) begin
            n_pos = (r_pos == LAST_POS) ? '0 : PW'(r_pos + 1'b1);
        end
    end

    assign out_free = !r_out_valid || o_res.ready;
    assign load_out = (r_state == S_DONE) && out_free;
    assign rd_en    = (r_state == S_SCAN);

    // sequencer
    always_comb begin
        n_state = r_state;
        op      = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    op      = OP_CLEAR;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                op = r_live ? OP_ACC : OP_NOP;
                if (r_idx == LAST_POS) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                op      = OP_ACC;
                n_state = S_MUL_T;
            end
            S_MUL_T: begin
                op      = OP_MUL_T;
                n_state = S_MUL_P;
            end
            S_MUL_P: begin
                op      = OP_MUL_P;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_live      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= rd_en;
            if (in_xfer) begin
                r_pos <= n_pos;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item context and scan index
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ch    <= i_smp.channel;
            r_blank <= !in_range;
            r_idx   <= '0;
        end else if (rd_en) begin
            r_idx <= PW'(r_idx + 1'b1);
        end
        if (load_out) begin
            r_out_ch    <= r_ch;
            r_out_trim  <= r_blank ? '0 : unit_trim;
            r_out_plain <= r_blank ? '0 : unit_plain;
        end
    end

    wtm_store #(
        .AW          (AW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_xfer && in_range),
        .i_wr_addr ({in_ch_ext[CH_W-1:0], n_pos}),
        .i_wr_data (i_smp.sample[SAMPLE_BITS-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr ({cur_ch_ext[CH_W-1:0], r_idx}),
        .o_rd_data (rd_data)
    );

    wtm_unit #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_unit (
        .i_clk     (i_clk),
        .i_op      (op),
        .i_data    (rd_data),
        .o_trimmed (unit_trim),
        .o_plain   (unit_plain)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.result_channel = r_out_ch;
    assign o_res.trimmed_mean   = SMP_FIELD_W'(r_out_trim);
    assign o_res.plain_mean     = SMP_FIELD_W'(r_out_plain);

    `ASSERT_WARM(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE))
    `ASSERT_SYNC(a_blank_is_zero, i_clk, i_rst_n, (load_out && r_blank) |=> ((r_out_trim == '0) && (r_out_plain == '0)))
    `ASSERT_SYNC(a_advance_moves, i_clk, i_rst_n, (in_xfer && i_smp.advance) |=> (r_pos != $past(r_pos)))

endmodule

// ===== sim/wtm_result_checker.sv =====
// Result checker for the windowed trimmed-mean filter: predicts window means and compares.
`timescale 1ns / 1ps

module wtm_result_checker import wtm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    wtm_in_if    i_smp_mon,
    wtm_out_if   i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int CHANNELS    = 8;
    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int TRIM_COUNT  = WINDOW - 2;
    localparam logic [SMP_FIELD_W-1:0] SAMPLE_MASK = SMP_FIELD_W'((1 << SAMPLE_BITS) - 1);

    typedef struct packed {
        logic [CH_FIELD_W-1:0]  channel;
        logic [SMP_FIELD_W-1:0] trimmed;
        logic [SMP_FIELD_W-1:0] plain;
    } t_window_means;

    logic [SMP_FIELD_W-1:0] window_store [CHANNELS][WINDOW];
    logic [3:0]             write_pos;
    t_window_means          expected_means [$];

    // Store the sample at the (possibly advanced) shared position and queue both means.
    task automatic absorb_sample(input logic [CH_FIELD_W-1:0] ch,
                                 input logic [SMP_FIELD_W-1:0] smp, input logic adv);
        int unsigned   total;
        int unsigned   largest;
        int unsigned   smallest;
        t_window_means means;
        if (adv) begin
            write_pos = (write_pos == 4'(WINDOW - 1)) ? 4'd0 : write_pos + 4'd1;
        end
        means.channel = ch;
        means.trimmed = '0;
        means.plain   = '0;
        if (int'(ch) < CHANNELS) begin
            window_store[ch][write_pos] = smp & SAMPLE_MASK;
            total    = 0;
            largest  = 0;
            smallest = 65535;
            for (int e = 0; e < WINDOW; e++) begin
                total += window_store[ch][e];
                if (window_store[ch][e] > largest)  largest  = window_store[ch][e];
                if (window_store[ch][e] < smallest) smallest = window_store[ch][e];
            end
            means.trimmed = SMP_FIELD_W'((total - largest - smallest + TRIM_COUNT / 2)
                                         / TRIM_COUNT);
            means.plain   = SMP_FIELD_W'((total + WINDOW / 2) / WINDOW);
        end
        expected_means.push_back(means);
    endtask

    task automatic check_result();
        t_window_means want;
        if (expected_means.size() == 0) begin
            $error("result for channel %0d arrived with no sample pending",
                   i_res_mon.result_channel);
            o_fail_count++;
        end else begin
            want = expected_means.pop_front();
            if (i_res_mon.result_channel !== want.channel) begin
                $error("result_channel mismatch: expected %0d, actual %0d",
                       want.channel, i_res_mon.result_channel);
                o_fail_count++;
            end
            if (i_res_mon.trimmed_mean !== want.trimmed) begin
                $error("trimmed_mean mismatch: expected %0d, actual %0d",
                       want.trimmed, i_res_mon.trimmed_mean);
                o_fail_count++;
            end
            if (i_res_mon.plain_mean !== want.plain) begin
                $error("plain_mean mismatch: expected %0d, actual %0d",
                       want.plain, i_res_mon.plain_mean);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int e = 0; e < WINDOW; e++) begin
                    window_store[c][e] = '0;
                end
            end
            write_pos = '0;
            expected_means.delete();
        end else begin
            if (i_res_mon.valid === 1'b1 && i_res_mon.ready === 1'b1) begin
                check_result();
            end
            if (i_smp_mon.valid === 1'b1 && i_smp_mon.ready === 1'b1) begin
                absorb_sample(i_smp_mon.channel, i_smp_mon.sample, i_smp_mon.advance);
            end
        end
        o_pending = expected_means.size();
    end

endmodule

// ===== sim/tb_windowed_trimmed_mean_filter.sv =====
// Testbench top for the windowed trimmed-mean filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_windowed_trimmed_mean_filter import wtm_pkg::*;;

    localparam int TOTAL_ITEMS    = 900;   // stop offering samples once this many went in
    localparam int QUIET_ITEMS    = 120;   // tail of the run with no idling on either side
    localparam int LONG_HOLD      = 400;   // receiver hold-off, long enough to fill the block
    localparam int DRAIN_CYCLES   = 40;    // settle time after the final drain, for a stray result to show
    localparam int WATCHDOG_LIMIT = 2500;  // cycles with no transfer on either channel

    logic i_clk;
    logic i_rst_n;

    wtm_in_if  smp_if ();
    wtm_out_if res_if ();

    int fail_count;
    int pending_means;

    // Flags of the sample driver; all but gaps_on are shared with the result sink.
    logic hold_req;
    logic hold_done;
    logic quiet_tail;
    logic gaps_on;

    int sent_items;
    int full_scans;
    int noise_items;
    logic [SMP_FIELD_W-1:0] level_base [8];

    windowed_trimmed_mean_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if)
    );

    wtm_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp_mon    (smp_if),
        .i_res_mon    (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_means)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Pick a sample: mostly near the channel's current level so the window
    // holds close values and the dropped max/min matter, with extremes and
    // full-range values mixed in.
    function automatic logic [SMP_FIELD_W-1:0] pick_sample(input int ch);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return SMP_FIELD_W'($urandom);
            default: return level_base[ch] + SMP_FIELD_W'($urandom_range(0, 63))
                            - SMP_FIELD_W'(32);
        endcase
    endfunction

    // Offer one sample and hold it until the block takes it. Enter and leave
    // at a falling edge; a gap drops valid for a burst first.
    task automatic send_sample(input int ch, input logic [SMP_FIELD_W-1:0] smp,
                               input logic adv);
        if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.channel <= CH_FIELD_W'(ch);
        smp_if.sample  <= smp;
        smp_if.advance <= adv;
        do @(posedge i_clk); while (smp_if.ready !== 1'b1);
        sent_items++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        wait (pending_means == 0);
        @(negedge i_clk);
    endtask

    // One scan in order: advance the shared position on channel 0 only.
    task automatic send_scan();
        for (int c = 0; c < 8; c++) begin
            send_sample(c, pick_sample(c), c == 0);
        end
        full_scans++;
    endtask

    // Result sink: random stall bursts, quiet stretches, and one long hold
    // on request, counted here while the driver keeps offering.
    initial begin : result_sink
        int segment_left;
        logic stall_on;
        res_if.ready = 1'b0;
        hold_done    = 1'b0;
        segment_left = 0;
        stall_on     = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (segment_left == 0) begin
                stall_on     = ($urandom_range(0, 2) != 0);
                segment_left = $urandom_range(50, 300);
            end
            segment_left--;
            if (hold_req && !hold_done) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (stall_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // End the run if neither channel moves for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((smp_if.valid === 1'b1 && smp_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : sample_driver
        logic mid_drain_done;
        int   mode;
        int   start_ch;
        int   span;
        // Drive every input to a known value before the first edge.
        i_rst_n        = 1'b0;
        smp_if.valid   = 1'b0;
        smp_if.channel = '0;
        smp_if.sample  = '0;
        smp_if.advance = 1'b0;
        hold_req       = 1'b0;
        quiet_tail     = 1'b0;
        gaps_on        = 1'b0;
        sent_items     = 0;
        full_scans     = 0;
        noise_items    = 0;
        mid_drain_done = 1'b0;
        for (int c = 0; c < 8; c++) level_base[c] = SMP_FIELD_W'($urandom);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, back to back.
        send_sample(0, '0, 1'b0);        // all-zero window after reset
        send_sample(7, '1, 1'b0);        // lone full-scale value is the trimmed maximum
        for (int k = 0; k < 16; k++) begin
            send_sample(3, '1, 1'b1);    // walk the position all the way round and wrap
        end
        send_sample(3, '0, 1'b0);        // full-scale window with a single zero
        send_sample(5, 12'hAAA, 1'b1);
        send_sample(6, 12'h555, 1'b0);
        wait_drained();

        // Long receiver hold while a scan keeps coming: the block must fill and stall.
        hold_req = 1'b1;
        send_scan();
        wait (hold_done === 1'b1);
        hold_req = 1'b0;

        // Random part: mostly well-formed scans, some stray and broken sequences.
        while (sent_items < TOTAL_ITEMS) begin
            if (sent_items >= TOTAL_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            if (!mid_drain_done && sent_items >= TOTAL_ITEMS / 2) begin
                wait_drained();
                mid_drain_done = 1'b1;
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                level_base[$urandom_range(0, 7)] = SMP_FIELD_W'($urandom);
            end
            mode = $urandom_range(0, 9);
            if (mode <= 6) begin
                send_scan();
            end else if (mode <= 8) begin
                // Noise: any channel, any sample, advance at random.
                repeat ($urandom_range(1, 6)) begin
                    send_sample($urandom_range(0, 7), SMP_FIELD_W'($urandom),
                                1'($urandom_range(0, 1)));
                    noise_items++;
                end
            end else begin
                // Broken scan: odd start, short or overlong, stray advances.
                start_ch = $urandom_range(0, 7);
                span     = $urandom_range(2, 10);
                for (int k = 0; k < span; k++) begin
                    send_sample((start_ch + k) % 8, pick_sample((start_ch + k) % 8),
                                $urandom_range(0, 4) == 0);
                end
            end
        end

        // Let every result come back, then give the block time to show a stray one.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d sample transfers: %0d full scans, %0d stray samples,",
                 sent_items, full_scans, noise_items);
        $display("position wrap, full-scale and zero windows, result stalls and drain pauses.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
